// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("port check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

// File: rtl/ohf_pkg.sv
`default_nettype none
package ohf_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_FIELD_DEF  = 60;

  localparam int NUM_W   = 64;
  localparam int WIDTH_W = 6;
  localparam int PREC_W  = 7;
  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 6;

  // Sequencer states; the output phases are in emission order.
  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE = 4'd0;
  localparam logic [ST_W-1:0] S_NORM = 4'd1;
  localparam logic [ST_W-1:0] S_CALC = 4'd2;
  localparam logic [ST_W-1:0] S_PLAN = 4'd3;
  localparam logic [ST_W-1:0] S_LPAD = 4'd4;
  localparam logic [ST_W-1:0] S_PFX0 = 4'd5;
  localparam logic [ST_W-1:0] S_PFXX = 4'd6;
  localparam logic [ST_W-1:0] S_ZPAD = 4'd7;
  localparam logic [ST_W-1:0] S_PREC = 4'd8;
  localparam logic [ST_W-1:0] S_DIG  = 4'd9;
  localparam logic [ST_W-1:0] S_RPAD = 4'd10;

  localparam int PH_FIRST = 4;
  localparam int PH_LAST  = 10;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
  localparam logic [3:0]        DEC_BASE = 4'd10;

  typedef struct packed {
    logic            load;
    logic            norm;
    logic            calc;
    logic            cnt_load;
    logic [ST_W-1:0] load_sel;
    logic            cnt_dec;
    logic            emit;
    logic [ST_W-1:0] phase;
    logic            shift;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic                      top_zero;
    logic                      nd_one;
    logic                      cnt_one;
    logic                      emit_ok;
    logic [PH_LAST:PH_FIRST]   on;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/ohf_ctrl.sv
`default_nettype none
module ohf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ohf_pkg::sts_t sts,
  output ohf_pkg::cmd_t cmd
);
  import ohf_pkg::*;

  logic [ST_W-1:0] state;
  logic [ST_W-1:0] state_next;
  logic [ST_W-1:0] follow;

  // first phase after st that has characters to send, else idle
  function automatic logic [ST_W-1:0] first_on(input logic [ST_W-1:0] st,
                                               input logic [PH_LAST:PH_FIRST] on);
    logic [ST_W-1:0] res;
    logic            found;
    res   = S_IDLE;
    found = 1'b0;
    for (int k = PH_FIRST; k <= PH_LAST; k++) begin
      if (!found && (ST_W'(k) > st) && on[k]) begin
        res   = ST_W'(k);
        found = 1'b1;
      end
    end
    return res;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign follow   = first_on(state, sts.on);

  always_comb begin
    cmd        = '0;
    cmd.phase  = state;
    state_next = state;
    unique case (state) inside
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        // drop leading zero digits, keep at least one
        if (sts.top_zero && !sts.nd_one) begin
          cmd.norm = 1'b1;
        end else begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_PLAN;
      end
      S_PLAN: begin
        cmd.cnt_load = 1'b1;
        cmd.load_sel = follow;
        state_next   = follow;
      end
      S_LPAD, S_PFX0, S_PFXX, S_ZPAD, S_PREC, S_DIG, S_RPAD: begin
        if (sts.emit_ok) begin
          cmd.emit  = 1'b1;
          cmd.shift = (state == S_DIG);
          if (sts.cnt_one) begin
            cmd.last     = (follow == S_IDLE);
            cmd.cnt_load = (follow != S_IDLE);
            cmd.load_sel = follow;
            state_next   = follow;
          end else begin
            cmd.cnt_dec = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ohf_datapath.sv
`default_nettype none
module ohf_datapath #(
  parameter int VALUE_BITS = ohf_pkg::VALUE_BITS_DEF,
  parameter int MAX_FIELD  = ohf_pkg::MAX_FIELD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ohf_pkg::cmd_t                 cmd,
  output ohf_pkg::sts_t                 sts,
  input  logic                          opcode,
  input  logic [ohf_pkg::NUM_W-1:0]     number,
  input  logic                          upper_case,
  input  logic [ohf_pkg::WIDTH_W-1:0]   field_width,
  input  logic signed [ohf_pkg::PREC_W-1:0] min_digits,
  input  logic                          alt_form,
  input  logic                          left_justify,
  input  logic                          zero_fill,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ohf_pkg::CHAR_W-1:0]    out_char,
  output logic                          last_char,
  output logic [ohf_pkg::LEN_W-1:0]     field_length
);
  import ohf_pkg::*;

  localparam int ND_O = (VALUE_BITS + 2) / 3;
  localparam int ND_H = (VALUE_BITS + 3) / 4;
  localparam int SHW  = (ND_O * 3 > ND_H * 4) ? ND_O * 3 : ND_H * 4;
  localparam int NDW  = $clog2(ND_O + 1);

  logic [SHW-1:0]     sh;
  logic [NDW-1:0]     nd;
  logic               hex;
  logic               upper;
  logic               alt;
  logic               left;
  logic               zfill;
  logic               nz;
  logic               given;
  logic [WIDTH_W-1:0] width;
  logic [WIDTH_W-1:0] prec;
  logic [1:0]         pfx;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   lpad_cnt;
  logic [LEN_W-1:0]   zpad_cnt;
  logic [LEN_W-1:0]   prec_cnt;
  logic [LEN_W-1:0]   rpad_cnt;
  logic [LEN_W-1:0]   cnt;

  logic [3:0]         top;
  logic [LEN_W-1:0]   nd6;
  logic [LEN_W-1:0]   prec_e;
  logic [LEN_W-1:0]   body;
  logic [1:0]         pfx_c;
  logic [LEN_W-1:0]   total;
  logic [LEN_W-1:0]   pad;
  logic               zpad;
  logic [LEN_W-1:0]   cnt_src;
  logic [CHAR_W-1:0]  dig_char;
  logic [CHAR_W-1:0]  ch;

  assign top = hex ? sh[ND_H*4-1 -: 4] : {1'b0, sh[ND_O*3-1 -: 3]};

  // field layout arithmetic, all on six-bit values
  always_comb begin
    nd6    = LEN_W'(nd);
    prec_e = given ? prec : '0;
    body   = (prec_e > nd6) ? prec_e : nd6;
    if (alt && nz) begin
      if (hex) begin
        pfx_c = 2'd2;
      end else begin
        pfx_c = (!given || (prec <= nd6)) ? 2'd1 : 2'd0;
      end
    end else begin
      pfx_c = 2'd0;
    end
    total = body + LEN_W'(pfx_c);
    pad   = (width > total) ? width - total : '0;
    zpad  = zfill && !left && !given;
  end

  always_comb begin
    unique case (cmd.load_sel) inside
      S_LPAD:         cnt_src = lpad_cnt;
      S_PFX0, S_PFXX: cnt_src = LEN_W'(1);
      S_ZPAD:         cnt_src = zpad_cnt;
      S_PREC:         cnt_src = prec_cnt;
      S_DIG:          cnt_src = nd6;
      S_RPAD:         cnt_src = rpad_cnt;
      default:        cnt_src = '0;
    endcase
  end

  always_comb begin
    if (top < DEC_BASE) begin
      dig_char = CH_ZERO + CHAR_W'(top);
    end else begin
      dig_char = (upper ? CH_A_UP : CH_A_LO) + CHAR_W'(top - DEC_BASE);
    end
    unique case (cmd.phase) inside
      S_LPAD, S_RPAD:         ch = CH_SPACE;
      S_PFX0, S_ZPAD, S_PREC: ch = CH_ZERO;
      S_PFXX:                 ch = upper ? CH_X_UP : CH_X_LO;
      S_DIG:                  ch = dig_char;
      default:                ch = CH_SPACE;
    endcase
  end

  always_comb begin
    sts.top_zero = (top == 4'd0);
    sts.nd_one   = (nd == NDW'(1));
    sts.cnt_one  = (cnt == LEN_W'(1));
    sts.emit_ok  = !out_valid || out_ready;
    sts.on       = {rpad_cnt != '0, 1'b1, prec_cnt != '0, zpad_cnt != '0,
                    pfx == 2'd2, pfx != 2'd0, lpad_cnt != '0};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sh    <= SHW'(number[VALUE_BITS-1:0]);
      nd    <= opcode ? NDW'(ND_H) : NDW'(ND_O);
      nz    <= |number[VALUE_BITS-1:0];
      hex   <= opcode;
      upper <= upper_case;
      alt   <= alt_form;
      left  <= left_justify;
      zfill <= zero_fill;
      width <= (field_width > WIDTH_W'(MAX_FIELD)) ? WIDTH_W'(MAX_FIELD) : field_width;
      given <= !min_digits[PREC_W-1];
      prec  <= (min_digits[WIDTH_W-1:0] > WIDTH_W'(MAX_FIELD)) ?
               WIDTH_W'(MAX_FIELD) : min_digits[WIDTH_W-1:0];
    end else if (cmd.norm || cmd.shift) begin
      sh <= hex ? (sh << 4) : (sh << 3);
      if (cmd.norm) begin
        nd <= nd - NDW'(1);
      end
    end
    if (cmd.calc) begin
      pfx      <= pfx_c;
      len      <= (width > total) ? width : total;
      lpad_cnt <= (!left && !zpad) ? pad : '0;
      zpad_cnt <= zpad ? pad : '0;
      rpad_cnt <= left ? pad : '0;
      prec_cnt <= (prec_e > nd6) ? prec_e - nd6 : '0;
    end
    if (cmd.cnt_load) begin
      cnt <= cnt_src;
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - LEN_W'(1);
    end
  end

  // output register: hold the character until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char     <= ch;
      last_char    <= cmd.last;
      field_length <= cmd.last ? len : '0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/octal_hex_field_formatter_unit.sv
`default_nettype none
// channel  handshake            payload
// -------  -------------------  ----------------------------------------------
// in       in_valid / in_ready  opcode number upper_case field_width min_digits
//                               alt_form left_justify zero_fill
// out      out_valid/out_ready  out_char last_char field_length
//
// One item takes an accept step, a leading-zero digit scan over up to D digit
// slots (D = 22 octal or 16 hex digit slots at 64 bits), the layout states
// S_CALC and S_PLAN, then one character per cycle while out_ready allows
// (1 to 62 characters per item).
// The digit scan loop and the character sequencer set how long an item takes.
// A low out_ready holds the sequencer; the next item is taken as soon as the
// last character sits in the output register.
// rst is synchronous and clears the sequencer and the output valid flag.
module octal_hex_field_formatter_unit #(
  parameter int VALUE_BITS = ohf_pkg::VALUE_BITS_DEF,
  parameter int MAX_FIELD  = ohf_pkg::MAX_FIELD_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic [ohf_pkg::NUM_W-1:0]         number,
  input  logic                              upper_case,
  input  logic [ohf_pkg::WIDTH_W-1:0]       field_width,
  input  logic signed [ohf_pkg::PREC_W-1:0] min_digits,
  input  logic                              alt_form,
  input  logic                              left_justify,
  input  logic                              zero_fill,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ohf_pkg::CHAR_W-1:0]        out_char,
  output logic                              last_char,
  output logic [ohf_pkg::LEN_W-1:0]         field_length
);
  import ohf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ohf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ohf_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_FIELD  (MAX_FIELD)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (opcode),
    .number       (number),
    .upper_case   (upper_case),
    .field_width  (field_width),
    .min_digits   (min_digits),
    .alt_form     (alt_form),
    .left_justify (left_justify),
    .zero_fill    (zero_fill),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .last_char    (last_char),
    .field_length (field_length)
  );

endmodule
`default_nettype wire

// File: rtl/ohf_checker.sv
`default_nettype none
`include "assert_macros.svh"
module ohf_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [ohf_pkg::CHAR_W-1:0] out_char,
  input  logic                       last_char,
  input  logic [ohf_pkg::LEN_W-1:0]  field_length
);
  import ohf_pkg::*;

  // the length rides only on the closing character of a field
  `ASSERT_SAME(a_len_on_last, out_valid && last_char, field_length != '0)
  `ASSERT_SAME(a_len_zero_mid, out_valid && !last_char, field_length == '0)
  // a taken item keeps the input closed for at least the next cycle
  `ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  // a stalled character holds
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char))

endmodule

bind octal_hex_field_formatter_unit ohf_checker u_chk (.*);
`default_nettype wire
